@@ src/att_pkg.sv @@
`default_nettype none

package att_pkg;

    // pipeline depths of the iterative units
    localparam int SqrtSteps   = 16;
    localparam int CordicSteps = 16;
    localparam int DivSteps    = 16;

    // cordic datapath widths
    localparam int CordicW = 34;
    localparam int AngW    = 19;

    // stage numbers of the main pipeline
    localparam int StgSq   = 1;
    localparam int StgRxy  = StgSq + SqrtSteps;
    localparam int StgTilt = StgRxy + CordicSteps + 1;
    localparam int StgNum  = StgTilt + 1;
    localparam int StgQ    = StgNum + DivSteps;
    localparam int StgAdj  = StgQ + 1;
    localparam int StgSum  = StgAdj + 1;
    localparam int StgBank = StgAdj + CordicSteps + 1;
    localparam int StgFin  = StgBank + 1;

    // fixed-point constants
    localparam logic [16:0]           GravityQ8    = 17'd2511;
    localparam logic [20:0]           DegToRadQ26  = 21'd1171270;
    localparam logic [15:0]           ThrustMul    = 16'd53441;
    localparam logic [15:0]           ThrustLowQ11 = 16'd614;
    localparam logic [15:0]           ThrustOneQ11 = 16'd2048;
    localparam logic signed [AngW-1:0] PiQ13       = 19'sd25736;
    localparam logic [15:0]           MaxRadReset  = 16'((30 * 1171270 + 4096) >> 13);

    // data that travels alongside the arithmetic units
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [16:0] az;
        logic [30:0]        sz;
        logic               zero;
        logic               az_pos;
        logic               scaled;
    } side_t;

    // arctangent of 2^-i in units of 2^-16 rad
    function automatic logic signed [AngW-1:0] atan_step(input int i);
        logic signed [AngW-1:0] t;
        case (i)
            0:       t = 19'sd51472;
            1:       t = 19'sd30386;
            2:       t = 19'sd16055;
            3:       t = 19'sd8150;
            4:       t = 19'sd4091;
            5:       t = 19'sd2047;
            6:       t = 19'sd1024;
            7:       t = 19'sd512;
            8:       t = 19'sd256;
            9:       t = 19'sd128;
            10:      t = 19'sd64;
            11:      t = 19'sd32;
            12:      t = 19'sd16;
            13:      t = 19'sd8;
            14:      t = 19'sd4;
            15:      t = 19'sd2;
            default: t = '0;
        endcase
        return t;
    endfunction

    // whole degrees to Q3.13 radians, rounded
    function automatic logic [15:0] deg_to_rad(input logic [7:0] deg);
        logic [28:0] p;
        p = 29'(deg) * 29'(DegToRadQ26) + 29'd4096;
        return p[28:13];
    endfunction

endpackage

`default_nettype wire

@@ src/att_if.sv @@
`default_nettype none

// command request channel
interface att_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_accel_x;
    logic signed [15:0] cmd_accel_y;
    logic signed [15:0] cmd_accel_z;

    modport source (output valid, output cmd_accel_x, output cmd_accel_y,
                    output cmd_accel_z, input ready);
    modport sink (input valid, input cmd_accel_x, input cmd_accel_y,
                  input cmd_accel_z, output ready);
endinterface

// result request channel
interface att_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] bank_about_x;
    logic signed [15:0] bank_about_y;
    logic [15:0]        thrust_factor;

    modport source (output valid, output bank_about_x, output bank_about_y,
                    output thrust_factor, input ready);
    modport sink (input valid, input bank_about_x, input bank_about_y,
                  input thrust_factor, output ready);
endinterface

// configuration write channel
interface att_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_lean_deg;

    modport source (output valid, output max_lean_deg, input ready);
    modport sink (input valid, input max_lean_deg, output ready);
endinterface

`default_nettype wire

@@ src/att_isqrt.sv @@
`default_nettype none

module att_isqrt
    import att_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] radicand,
    output logic [15:0]      root
);

    logic [31:0] val_reg  [SqrtSteps];
    logic [17:0] rem_reg  [SqrtSteps];
    logic [15:0] root_reg [SqrtSteps];

    // one result bit per stage, digit by digit
    for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
        logic [31:0] v_in;
        logic [17:0] r_in;
        logic [15:0] q_in;
        logic [19:0] acc;
        logic [19:0] trial;

        if (j == 0) begin : g_first
            assign v_in = radicand;
            assign r_in = '0;
            assign q_in = '0;
        end
        else begin : g_next
            assign v_in = val_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = root_reg[j-1];
        end

        assign acc   = {r_in, v_in[31-2*j -: 2]};
        assign trial = {2'b00, q_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[j] <= v_in;
                if (acc >= trial)
                begin
                    rem_reg[j]  <= 18'(acc - trial);
                    root_reg[j] <= {q_in[14:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= acc[17:0];
                    root_reg[j] <= {q_in[14:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SqrtSteps-1];

endmodule

`default_nettype wire

@@ src/att_cordic.sv @@
`default_nettype none

module att_cordic
    import att_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [17:0] y_in,
    input  wire logic signed [16:0] x_in,
    output logic signed [15:0]      angle
);

    logic signed [CordicW-1:0] x_reg [CordicSteps];
    logic signed [CordicW-1:0] y_reg [CordicSteps];
    logic signed [AngW-1:0]    z_reg [CordicSteps];
    logic signed [15:0]        ang_reg;

    logic signed [CordicW-1:0] x_ext;
    logic signed [CordicW-1:0] y_ext;
    logic signed [AngW-1:0]    z_rnd;
    logic signed [AngW-1:0]    z_shr;

    // operands scaled by 2^14
    assign x_ext = {{(CordicW-31){x_in[16]}}, x_in, 14'b0};
    assign y_ext = {{(CordicW-32){y_in[17]}}, y_in, 14'b0};

    // vectoring iterations, one per stage
    for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
        logic signed [CordicW-1:0] xi;
        logic signed [CordicW-1:0] yi;
        logic signed [AngW-1:0]    zi;
        logic signed [CordicW-1:0] dx;
        logic signed [CordicW-1:0] dy;
        logic signed [AngW-1:0]    tab;
        logic                      up;

        if (i == 0) begin : g_first
            assign xi = x_ext;
            assign yi = y_ext;
            assign zi = '0;
        end
        else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign dx  = yi >>> i;
        assign dy  = xi >>> i;
        assign up  = !yi[CordicW-1] && (yi != '0);
        assign tab = atan_step(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (up)
                begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + tab;
                end
                else
                begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - tab;
                end
            end
        end
    end

    // round to Q3.13 and limit to plus or minus pi
    assign z_rnd = z_reg[CordicSteps-1] + 19'sd4;
    assign z_shr = z_rnd >>> 3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_shr > PiQ13)
                ang_reg <= PiQ13[15:0];
            else if (z_shr < -PiQ13)
                ang_reg <= 16'(-PiQ13);
            else
                ang_reg <= z_shr[15:0];
        end
    end

    assign angle = ang_reg;

endmodule

`default_nettype wire

@@ src/att_div.sv @@
`default_nettype none

module att_div
    import att_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] num_a,
    input  wire logic [31:0] num_b,
    input  wire logic [15:0] den,
    output logic [15:0]      quo_a,
    output logic [15:0]      quo_b
);

    logic [31:0] na_reg [DivSteps];
    logic [31:0] nb_reg [DivSteps];
    logic [15:0] qa_reg [DivSteps];
    logic [15:0] qb_reg [DivSteps];
    logic [15:0] d_reg  [DivSteps];

    // restoring division, one quotient bit per stage, msb first
    for (genvar t = 0; t < DivSteps; t++) begin : g_step
        logic [31:0] na_in;
        logic [31:0] nb_in;
        logic [15:0] qa_in;
        logic [15:0] qb_in;
        logic [15:0] d_in;
        logic [31:0] dsh;

        if (t == 0) begin : g_first
            assign na_in = num_a;
            assign nb_in = num_b;
            assign qa_in = '0;
            assign qb_in = '0;
            assign d_in  = den;
        end
        else begin : g_next
            assign na_in = na_reg[t-1];
            assign nb_in = nb_reg[t-1];
            assign qa_in = qa_reg[t-1];
            assign qb_in = qb_reg[t-1];
            assign d_in  = d_reg[t-1];
        end

        assign dsh = {16'b0, d_in} << (DivSteps - 1 - t);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[t] <= d_in;
                if (na_in >= dsh)
                begin
                    na_reg[t] <= na_in - dsh;
                    qa_reg[t] <= {qa_in[14:0], 1'b1};
                end
                else
                begin
                    na_reg[t] <= na_in;
                    qa_reg[t] <= {qa_in[14:0], 1'b0};
                end
                if (nb_in >= dsh)
                begin
                    nb_reg[t] <= nb_in - dsh;
                    qb_reg[t] <= {qb_in[14:0], 1'b1};
                end
                else
                begin
                    nb_reg[t] <= nb_in;
                    qb_reg[t] <= {qb_in[14:0], 1'b0};
                end
            end
        end
    end

    assign quo_a = qa_reg[DivSteps-1];
    assign quo_b = qb_reg[DivSteps-1];

endmodule

`default_nettype wire

@@ src/accel_to_tilt_and_thrust.sv @@
// accel_to_tilt_and_thrust
// Turns a commanded acceleration (Q7.8 m/s^2, gravity added to z) into two
// bank angles (Q3.13 rad) and a thrust factor (Q5.11).
// Channels: cmd takes one request per acceleration, res gives exactly one
// request per command in the same order, cfg writes max_lean_deg (degrees).
// cfg is always ready; write it only while no command is in flight.
// Throughput: one command per clock cycle unless a stall on res holds the
// pipeline. The depth is set by the serial chain square root, tilt cordic,
// 16-step divider, then the bank cordics and length square root side by
// side, one bit or one iteration per stage.
// Reset: all stage valid bits and the output valid clear, max_lean_deg goes
// to 30 degrees.
// When res is stalled with a result waiting, the pipeline keeps advancing
// as long as the item about to leave it is empty; otherwise the whole
// pipeline holds and cmd.ready drops. Nothing is lost or repeated.
`default_nettype none

module accel_to_tilt_and_thrust
    import att_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    att_cmd_if.sink    cmd,
    att_cfg_if.sink    cfg,
    att_res_if.source  res
);

    logic              adv;
    logic [15:0]       max_rad_reg;
    logic [StgFin:0]   v_reg;
    logic [StgFin:0]   v_next;
    side_t             side_reg  [StgFin+1];
    side_t             side_next [StgFin+1];

    logic signed [16:0] az_in;
    logic signed [15:0] s0_ax;
    logic signed [15:0] s0_ay;
    logic signed [16:0] s0_az;
    logic signed [31:0] ax_sq;
    logic signed [31:0] ay_sq;
    logic signed [33:0] az_sq;
    logic [31:0]        sxy_reg;

    logic [15:0]        rxy;
    logic signed [15:0] tilt;
    logic               scale_now;
    logic signed [15:0] t_ax;
    logic signed [15:0] t_ay;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
    logic [31:0]        num_x_reg;
    logic [31:0]        num_y_reg;
    logic [15:0]        den_reg;
    logic [15:0]        quo_x;
    logic [15:0]        quo_y;

    logic signed [15:0] adj_x;
    logic signed [15:0] adj_y;
    logic signed [15:0] a_ax;
    logic signed [15:0] a_ay;
    logic signed [31:0] axa_sq;
    logic signed [31:0] aya_sq;
    logic [31:0]        sum_reg;

    logic signed [15:0] ang_y;
    logic signed [15:0] ang_x;
    logic [15:0]        len;
    logic [31:0]        prod_reg;
    logic signed [15:0] by_reg;
    logic signed [15:0] bx_reg;

    logic [32:0]        thr_sum;
    logic [15:0]        thr_sat;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic signed [15:0] bank_x_reg;
    logic signed [15:0] bank_y_reg;
    logic [15:0]        thrust_reg;

    // limit an angle to plus or minus the configured lean
    function automatic logic signed [15:0] lean_limit(input logic signed [15:0] a,
                                                      input logic [15:0] m);
        logic signed [16:0] a17;
        logic signed [16:0] m17;
        logic signed [16:0] n17;
        a17 = {a[15], a};
        m17 = {1'b0, m};
        n17 = -m17;
        if (a17 > m17)
            return m17[15:0];
        if (a17 < n17)
            return n17[15:0];
        return a;
    endfunction

    // pipeline moves unless a finished item would overrun a waiting result
    assign adv       = !v_reg[StgFin] || !res_valid_reg || res.ready;
    assign cmd.ready = adv;
    assign cfg.ready = 1'b1;

    // configuration register, kept as radians
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_rad_reg <= MaxRadReset;
        else if (cfg.valid)
            max_rad_reg <= deg_to_rad(cfg.max_lean_deg);
    end

    // input with gravity added
    assign az_in = {cmd.cmd_accel_z[15], cmd.cmd_accel_z} + GravityQ8;

    // stage operands
    assign s0_ax = side_reg[0].ax;
    assign s0_ay = side_reg[0].ay;
    assign s0_az = side_reg[0].az;
    assign ax_sq = s0_ax * s0_ax;
    assign ay_sq = s0_ay * s0_ay;
    assign az_sq = s0_az * s0_az;

    assign t_ax  = side_reg[StgTilt].ax;
    assign t_ay  = side_reg[StgTilt].ay;
    assign mag_x = t_ax[15] ? 16'(~t_ax + 16'd1) : t_ax;
    assign mag_y = t_ay[15] ? 16'(~t_ay + 16'd1) : t_ay;
    assign scale_now = $signed({tilt[15], tilt}) > $signed({1'b0, max_rad_reg});

    // scaled components replace the originals when the tilt is too large
    always_comb
    begin
        adj_x = side_reg[StgQ].ax;
        adj_y = side_reg[StgQ].ay;
        if (side_reg[StgQ].scaled)
        begin
            adj_x = side_reg[StgQ].ax[15] ? 16'(~quo_x + 16'd1) : quo_x;
            adj_y = side_reg[StgQ].ay[15] ? 16'(~quo_y + 16'd1) : quo_y;
        end
    end

    assign a_ax   = side_reg[StgAdj].ax;
    assign a_ay   = side_reg[StgAdj].ay;
    assign axa_sq = a_ax * a_ax;
    assign aya_sq = a_ay * a_ay;

    // side data moves one stage, with updates at fixed stages
    always_comb
    begin
        side_next[0].ax     = cmd.cmd_accel_x;
        side_next[0].ay     = cmd.cmd_accel_y;
        side_next[0].az     = az_in;
        side_next[0].sz     = '0;
        side_next[0].zero   = (cmd.cmd_accel_x == '0) && (cmd.cmd_accel_y == '0)
                              && (az_in == '0);
        side_next[0].az_pos = !az_in[16] && (az_in != '0);
        side_next[0].scaled = 1'b0;
        for (int k = 1; k <= StgFin; k++)
            side_next[k] = side_reg[k-1];
        side_next[StgSq].sz      = az_sq[30:0];
        side_next[StgNum].scaled = scale_now;
        side_next[StgAdj].ax     = adj_x;
        side_next[StgAdj].ay     = adj_y;
    end

    assign v_next = {v_reg[StgFin-1:0], cmd.valid};

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    // side data registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= StgFin; k++)
                side_reg[k] <= side_next[k];
        end
    end

    // horizontal magnitude squared
    always_ff @(posedge clk)
    begin
        if (adv)
            sxy_reg <= {1'b0, ax_sq[30:0]} + {1'b0, ay_sq[30:0]};
    end

    att_isqrt u_sqrt_xy (
        .clk      (clk),
        .en       (adv),
        .radicand (sxy_reg),
        .root     (rxy)
    );

    // total tilt
    att_cordic u_tilt (
        .clk   (clk),
        .en    (adv),
        .y_in  ({2'b00, rxy}),
        .x_in  (side_reg[StgRxy].az),
        .angle (tilt)
    );

    // scale numerators and divisor
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_x_reg <= mag_x * max_rad_reg;
            num_y_reg <= mag_y * max_rad_reg;
            den_reg   <= tilt;
        end
    end

    att_div u_div (
        .clk   (clk),
        .en    (adv),
        .num_a (num_x_reg),
        .num_b (num_y_reg),
        .den   (den_reg),
        .quo_a (quo_x),
        .quo_b (quo_y)
    );

    // full vector length squared
    always_ff @(posedge clk)
    begin
        if (adv)
            sum_reg <= {1'b0, axa_sq[30:0]} + {1'b0, aya_sq[30:0]}
                       + {1'b0, side_reg[StgAdj].sz};
    end

    att_cordic u_bank_y (
        .clk   (clk),
        .en    (adv),
        .y_in  ({{2{a_ax[15]}}, a_ax}),
        .x_in  (side_reg[StgAdj].az),
        .angle (ang_y)
    );

    att_cordic u_bank_x (
        .clk   (clk),
        .en    (adv),
        .y_in  ({{2{a_ay[15]}}, a_ay}),
        .x_in  (side_reg[StgAdj].az),
        .angle (ang_x)
    );

    att_isqrt u_sqrt_len (
        .clk      (clk),
        .en       (adv),
        .radicand (sum_reg),
        .root     (len)
    );

    // thrust product and bank limiting
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= len * ThrustMul;
            if (side_reg[StgBank].scaled)
            begin
                by_reg <= lean_limit(ang_y, max_rad_reg);
                bx_reg <= lean_limit(ang_x, max_rad_reg);
            end
            else
            begin
                by_reg <= ang_y;
                bx_reg <= ang_x;
            end
        end
    end

    // thrust rounding and saturation
    assign thr_sum = {1'b0, prod_reg} + 33'd32768;
    assign thr_sat = thr_sum[32] ? 16'hFFFF : thr_sum[31:16];

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (adv && v_reg[StgFin])
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_reg[StgFin])
        begin
            if (side_reg[StgFin].zero)
            begin
                bank_x_reg <= '0;
                bank_y_reg <= '0;
                thrust_reg <= ThrustOneQ11;
            end
            else if (!side_reg[StgFin].az_pos)
            begin
                bank_x_reg <= '0;
                bank_y_reg <= '0;
                thrust_reg <= ThrustLowQ11;
            end
            else
            begin
                bank_x_reg <= -bx_reg;
                bank_y_reg <= by_reg;
                thrust_reg <= thr_sat;
            end
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.bank_about_x  = bank_x_reg;
    assign res.bank_about_y  = bank_y_reg;
    assign res.thrust_factor = thrust_reg;

    // accepted request enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> v_reg[0])
        else $error("accepted request did not enter the pipeline");

    // a blocked finished item stalls the input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[StgFin] && res.valid && !res.ready) |-> !cmd.ready)
        else $error("input taken while the pipeline is blocked");

    // the limited bank about y stays within the configured lean
    a_lean: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[StgFin] && side_reg[StgFin].scaled)
        |-> ($signed({by_reg[15], by_reg}) <= $signed({1'b0, max_rad_reg}))
            && ($signed({by_reg[15], by_reg}) >= -$signed({1'b0, max_rad_reg})))
        else $error("bank exceeds the configured lean");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } accel_t;

    typedef struct {
        logic signed [15:0] bank_x;
        logic signed [15:0] bank_y;
        logic [15:0]        thrust;
    } attitude_t;

    logic clk;
    logic rst_n;

    att_cmd_if cmd ();
    att_cfg_if cfg ();
    att_res_if res ();

    accel_to_tilt_and_thrust dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .res   (res)
    );

    accel_t    pending_cmds[$];
    attitude_t attitude_q[$];
    logic [7:0] lean_limit_deg;
    int errors;
    int cmds_sent;
    int results_seen;
    int hold_req;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // cordic arctangent of y over x, Q3.13 rad
    function automatic longint arctan2(input longint y, input longint x);
        longint tab[16];
        longint cx;
        longint cy;
        longint ang;
        longint t;
        longint dx;
        longint dy;
        longint r;
        tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        cx = x * 16384;
        cy = y * 16384;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        // quadrant pre-rotation
        if (cx < 0)
        begin
            t = cx;
            if (cy >= 0)
            begin
                cx = cy;
                cy = -t;
                ang = 102944;
            end
            else
            begin
                cx = -cy;
                cy = t;
                ang = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                ang = ang + tab[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                ang = ang - tab[i];
            end
        end
        r = (ang + 4) >>> 3;
        if (r > 25736)
            r = 25736;
        if (r < -25736)
            r = -25736;
        return r;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint shrink(input longint a, input longint num, input longint den);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * num) / den;
        return (a < 0) ? -mag : mag;
    endfunction

    // expected banks and thrust for one acceleration request
    function automatic attitude_t attitude_of(input accel_t c, input logic [7:0] deg);
        attitude_t o;
        longint ax;
        longint ay;
        longint az;
        longint bx;
        longint by;
        longint max_rad;
        longint tilt;
        longint unsigned len;
        longint unsigned thr;
        ax = c.ax;
        ay = c.ay;
        az = longint'(c.az) + 2511;
        len = int_sqrt(ax * ax + ay * ay + az * az);
        if (len == 0)
        begin
            o.bank_x = '0;
            o.bank_y = '0;
            o.thrust = 16'd2048;
            return o;
        end
        by = arctan2(ax, az);
        bx = -arctan2(ay, az);
        max_rad = (longint'(deg) * 1171270 + 4096) >>> 13;
        tilt = arctan2(longint'(int_sqrt(ax * ax + ay * ay)), az);
        // lean limit exceeded: scale horizontal part down
        if (tilt > max_rad)
        begin
            ax = shrink(ax, max_rad, tilt);
            ay = shrink(ay, max_rad, tilt);
            by = clamp_to(arctan2(ax, az), -max_rad, max_rad);
            bx = -clamp_to(arctan2(ay, az), -max_rad, max_rad);
            len = int_sqrt(ax * ax + ay * ay + az * az);
        end
        if (az <= 0)
        begin
            thr = 614;
            bx = 0;
            by = 0;
        end
        else
        begin
            thr = (len * 53441 + 32768) >> 16;
            if (thr > 65535)
                thr = 65535;
        end
        o.bank_x = 16'(clamp_to(bx, -32768, 32767));
        o.bank_y = 16'(clamp_to(by, -32768, 32767));
        o.thrust = 16'(thr);
        return o;
    endfunction

    // command driver, bursts and gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.cmd_accel_x <= '0;
            cmd.cmd_accel_y <= '0;
            cmd.cmd_accel_z <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!(cmd.valid && !cmd.ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                accel_t c;
                c = pending_cmds.pop_front();
                cmd.cmd_accel_x <= c.ax;
                cmd.cmd_accel_y <= c.ay;
                cmd.cmd_accel_z <= c.az;
                cmd.valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // predict on every accepted command
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
        begin
            accel_t c;
            c.ax = cmd.cmd_accel_x;
            c.ay = cmd.cmd_accel_y;
            c.az = cmd.cmd_accel_z;
            attitude_q.push_back(attitude_of(c, lean_limit_deg));
            cmds_sent++;
        end
    end

    // result monitor with its own stall pattern
    int hold_cnt;
    int mode_cnt;
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            hold_cnt = 0;
            mode_cnt = 0;
            stall_mode = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                attitude_t e;
                results_seen++;
                if (attitude_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d thrust=%0d", $time,
                             res.bank_about_x, res.bank_about_y, res.thrust_factor);
                end
                else
                begin
                    e = attitude_q.pop_front();
                    if (res.bank_about_x !== e.bank_x)
                    begin
                        errors++;
                        $display("%0t: bank_about_x expected %0d actual %0d", $time,
                                 e.bank_x, res.bank_about_x);
                    end
                    if (res.bank_about_y !== e.bank_y)
                    begin
                        errors++;
                        $display("%0t: bank_about_y expected %0d actual %0d", $time,
                                 e.bank_y, res.bank_about_y);
                    end
                    if (res.thrust_factor !== e.thrust)
                    begin
                        errors++;
                        $display("%0t: thrust_factor expected %0d actual %0d", $time,
                                 e.thrust, res.thrust_factor);
                    end
                end
            end
            if (hold_req != 0)
            begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (mode_cnt == 0)
            begin
                mode_cnt = $urandom_range(20, 120);
                stall_mode = $urandom_range(0, 3);
            end
            else
                mode_cnt--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= ($urandom_range(0, 3) != 0);
                    2:       res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd.valid || attitude_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_lean(input logic [7:0] deg);
        @(posedge clk);
        cfg.max_lean_deg <= deg;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        lean_limit_deg = deg;
        cfg.valid <= 1'b0;
    endtask

    function automatic accel_t mk(input int x, input int y, input int z);
        accel_t c;
        c.ax = 16'(x);
        c.ay = 16'(y);
        c.az = 16'(z);
        return c;
    endfunction

    function automatic accel_t rand_cmd();
        accel_t c;
        case ($urandom_range(0, 4))
            0:       c = mk($urandom, $urandom, $urandom);
            1:       c = mk($urandom_range(0, 65535), $urandom_range(0, 65535),
                            int'($urandom_range(0, 4000)) - 2000);
            default: c = mk(int'($urandom_range(0, 6000)) - 3000,
                            int'($urandom_range(0, 6000)) - 3000,
                            int'($urandom_range(0, 6000)) - 3000);
        endcase
        return c;
    endfunction

    // stimulus sequence
    initial
    begin
        logic [7:0] lean_settings[7];
        lean_settings = '{8'd0, 8'd180, 8'd255, 8'd1, 8'd45, 8'd90, 8'd10};
        errors = 0;
        cmds_sent = 0;
        results_seen = 0;
        hold_req = 0;
        lean_limit_deg = 8'd30;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.max_lean_deg = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset lean limit
        pending_cmds.push_back(mk(0, 0, 0));
        pending_cmds.push_back(mk(0, 0, -2511));
        pending_cmds.push_back(mk(32767, 32767, 32767));
        pending_cmds.push_back(mk(-32768, -32768, -32768));
        pending_cmds.push_back(mk(32767, -32768, 0));
        pending_cmds.push_back(mk(-32768, 32767, 0));
        pending_cmds.push_back(mk(0, 0, -32768));
        pending_cmds.push_back(mk(0, 0, 32767));
        pending_cmds.push_back(mk(100, 0, 0));
        pending_cmds.push_back(mk(0, -100, 0));
        pending_cmds.push_back(mk(500, 500, 0));
        pending_cmds.push_back(mk(5000, 0, -2511));
        pending_cmds.push_back(mk(-5000, 3000, -2512));
        pending_cmds.push_back(mk(-1, -1, -2510));
        pending_cmds.push_back(mk(1, 0, -2511));
        pending_cmds.push_back(mk(-1, 0, -2511));
        pending_cmds.push_back(mk(-3000, -3000, 2000));
        pending_cmds.push_back(mk(32767, 0, -2511));
        pending_cmds.push_back(mk(-32768, 0, 32767));
        pending_cmds.push_back(mk(0, 32767, 32767));
        wait_idle();

        // random phases across lean limits
        for (int p = 0; p <= 7; p++)
        begin
            if (p > 0)
                write_lean(lean_settings[p - 1]);
            // the hold-off phase sends more than the pipeline can hold
            for (int n = 0; n < ((p == 2) ? 120 : 40); n++)
                pending_cmds.push_back(rand_cmd());
            // long receiver hold-off while commands keep coming
            if (p == 2)
                hold_req = 1;
            wait_idle();
        end

        $display("ran %0d commands and checked %0d results over 8 lean limits",
                 cmds_sent, results_seen);
        $display("lean limits included 0, 1, 180, 255 and the reset value");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // overall time limit
    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
